/* hdl/dotgs_pkg.sv */
// Shared types and constants for the disc offset to group segment translator.
package dotgs_pkg;
   localparam int unsigned HDR_BYTES = 128;
   localparam int unsigned ALIGN_BITS = 15;
   localparam int unsigned CHUNK_MIN = 32768;
   localparam int unsigned CHUNK_MAX = 33554432;
   localparam int unsigned SEG_CAP = 16;

   localparam logic [1:0] KIND_HDR = 2'd0;
   localparam logic [1:0] KIND_GROUP = 2'd1;
   localparam logic [1:0] KIND_ZERO = 2'd2;

   localparam logic [1:0] CSR_CHUNK = 2'd0;
   localparam logic [1:0] CSR_GCOUNT = 2'd1;
   localparam logic [1:0] CSR_RCOUNT = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [24:0] src;
      logic [31:0] gidx;
      logic [35:0] gdo;
      logic [16:0] len;
      logic        trunc;
      logic        last;
   } seg_type;

   typedef struct packed {
      logic        start;
      logic [35:0] dividend;
      logic [25:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [35:0] quot;
      logic [25:0] rem;
   } div_rsp_type;
endpackage

/* hdl/disc_offset_to_group_segments.sv */
// Disc read translator: region table in memory, request walk into segments.
// Usage: req_ beats carry a table load (req_tuser=0) or a read (req_tuser=1).
// A load writes one region entry and yields no rsp_ beat.
// A read yields 0 to 16 rsp_ beats, rsp_tlast on the final one.
// A segment outside the header starts with a table scan, a memory read and
// then a compare for each entry searched, unless the current region is kept,
// then a 36-bit serial divide of the in-region offset by the chunk size.
// The walk holds each further segment until the previous beat has left the
// output register, and a read passes back through S_STEP to close unless its
// last segment was built as a zero fill. One item is worked at a time;
// req_tready is low while a read is walked. A segment waits in the output
// register when rsp_tready is low; the walk holds until it is taken. Reset
// clears control state and sets chunk_size to 2 MiB, group_count and
// region_count to 0; the region table is undefined until loaded.
// Configuration is written through csr_; the user must do so only while
// idle, as the block itself does not enforce it.
module disc_offset_to_group_segments #(
   parameter int unsigned MAX_REGIONS = 16,
   parameter int unsigned MAX_REQ_BYTES = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // lsb up: region_slot[3:0], region_offset[39:4], region_size[75:40],
   // region_first_group[107:76], req_offset[139:108], req_length[156:140]
   input  logic [159:0] req_tdata,
   // req_type
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // lsb up: seg_kind[1:0], source_offset[26:2], group_index[58:27],
   // group_disc_offset[94:59], seg_length[111:95], truncated[112]
   output logic [119:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import dotgs_pkg::*;

   localparam int unsigned AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
   localparam logic [16:0] MAXREQ = (MAX_REQ_BYTES >= 131071) ? 17'h1FFFF
                                    : 17'(MAX_REQ_BYTES);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_STEP, S_RD, S_CMP, S_DIV, S_DIVW, S_CALC, S_EMIT
   } state_type;

   function automatic seg_type mk_seg(logic [1:0] kind, logic [24:0] src,
                                      logic [31:0] gidx, logic [35:0] gdo,
                                      logic [16:0] len, logic trunc, logic last);
      seg_type s;
      s.kind = kind; s.src = src; s.gidx = gidx; s.gdo = gdo;
      s.len = len; s.trunc = trunc; s.last = last;
      return s;
   endfunction

   // region table memory
   logic [103:0] mem [MAX_REGIONS];
   logic [103:0] rd_ff;
   logic [AW-1:0] raddr;
   logic          mwe;
   logic [AW-1:0] waddr;
   logic [103:0]  wdata;

   always_ff @(posedge clock) begin
      if (mwe) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   logic [25:0] chunk_ff;
   logic [31:0] gcount_ff;
   logic [4:0]  rcount_ff;

   state_type   st_ff;
   logic [31:0] off_ff;
   logic [16:0] rem_ff;
   logic [4:0]  n_ff;
   logic        have_ff;
   logic [CW-1:0] scan_ff;
   logic [35:0] local_ff, rstart_ff, rlen_ff;
   logic [31:0] rgrp_ff;
   logic [25:0] cs_ff;
   logic        out_v_ff;
   seg_type     seg_ff;
   logic [103:0] ld_ff;
   logic [3:0]  slot_ff;

   div_req_type dreq;
   div_rsp_type drsp;
   dotgs_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign dreq = {st_ff == S_DIV, local_ff, cs_ff};

   logic [CW-1:0] nreg;
   assign nreg = ({27'd0, rcount_ff} > 32'(MAX_REGIONS)) ? CW'(MAX_REGIONS)
                                                         : CW'(rcount_ff);

   // load path: align start, grow length with saturation
   logic [35:0] l_off, l_size;
   logic [36:0] l_len;
   assign l_off = req_tdata[39:4];
   assign l_size = req_tdata[75:40];
   assign l_len = {1'b0, l_size} + {22'd0, l_off[ALIGN_BITS-1:0]};

   assign mwe = (st_ff == S_LOAD) && ({28'd0, slot_ff} < 32'(MAX_REGIONS));
   assign waddr = AW'(slot_ff);
   assign wdata = ld_ff;
   assign raddr = scan_ff[AW-1:0];

   assign req_tready = (st_ff == S_IDLE);

   // hit test on the entry just read
   logic [35:0] e_start, e_len;
   logic [36:0] e_end;
   logic        e_hit;
   assign e_start = rd_ff[103:68];
   assign e_len = rd_ff[67:32];
   assign e_end = {1'b0, e_start} + {1'b0, e_len};
   assign e_hit = ({4'd0, off_ff} >= e_start) && ({5'd0, off_ff} < e_end);

   logic [31:0] g_sum;
   logic [35:0] grel_cs;
   logic [25:0] seg_room;
   logic [35:0] left;
   logic [35:0] clen;
   assign g_sum = rgrp_ff + drsp.quot[31:0];
   assign left = rlen_ff - local_ff;
   // region-relative group index times chunk size, taken back from the remainder
   assign grel_cs = local_ff - {10'd0, drsp.rem};
   assign seg_room = cs_ff - drsp.rem;

   always_comb begin
      clen = {10'd0, seg_room};
      if (clen > {19'd0, rem_ff}) clen = {19'd0, rem_ff};
      if (clen > left) clen = left;
   end

   logic [16:0] hlen;
   assign hlen = 17'(HDR_BYTES) - {10'd0, off_ff[6:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; out_v_ff <= 1'b0;
         chunk_ff <= 26'd2097152; gcount_ff <= '0; rcount_ff <= '0;
         have_ff <= 1'b0; n_ff <= '0; seg_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CHUNK:  chunk_ff <= csr_wdata[25:0];
               CSR_GCOUNT: gcount_ff <= csr_wdata;
               CSR_RCOUNT: rcount_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
         out_v_ff <= (st_ff == S_EMIT) || (out_v_ff && !rsp_tready);
         unique case (st_ff)
            S_IDLE: if (req_tvalid) begin
               if (!req_tuser) begin
                  slot_ff <= req_tdata[3:0];
                  ld_ff <= {l_off[35:ALIGN_BITS], {ALIGN_BITS{1'b0}},
                            l_len[36] ? 36'hF_FFFF_FFFF : l_len[35:0],
                            req_tdata[107:76]};
                  st_ff <= S_LOAD;
               end else begin
                  off_ff <= req_tdata[139:108];
                  rem_ff <= (req_tdata[156:140] > MAXREQ) ? MAXREQ : req_tdata[156:140];
                  n_ff <= '0; have_ff <= 1'b0;
                  cs_ff <= (chunk_ff < 26'(CHUNK_MIN)) ? 26'(CHUNK_MIN) :
                           ({6'd0, chunk_ff} > 32'(CHUNK_MAX)) ? 26'(CHUNK_MAX)
                           : chunk_ff;
                  st_ff <= S_STEP;
               end
            end
            S_LOAD: st_ff <= S_IDLE;
            S_STEP: begin
               if (rem_ff == 17'd0 || n_ff == 5'(SEG_CAP)) begin
                  st_ff <= S_IDLE;
               end else if (!out_v_ff) begin
                  if (off_ff < 32'(HDR_BYTES)) begin
                     seg_ff <= mk_seg(KIND_HDR, {18'd0, off_ff[6:0]}, '0, '0,
                                      (hlen > rem_ff) ? rem_ff : hlen, 1'b0, 1'b0);
                     have_ff <= 1'b0;
                     st_ff <= S_EMIT;
                  end else if (have_ff && local_ff < rlen_ff) begin
                     st_ff <= S_DIV;
                  end else begin
                     have_ff <= 1'b0;
                     scan_ff <= '0;
                     st_ff <= S_RD;
                  end
               end
            end
            S_RD: begin
               if (scan_ff >= nreg) begin
                  seg_ff <= mk_seg(KIND_ZERO, '0, '0, '0, rem_ff, 1'b0, 1'b0);
                  st_ff <= S_EMIT;
               end else st_ff <= S_CMP;
            end
            S_CMP: begin
               if (e_hit) begin
                  have_ff <= 1'b1;
                  rstart_ff <= e_start; rlen_ff <= e_len; rgrp_ff <= rd_ff[31:0];
                  local_ff <= {4'd0, off_ff} - e_start;
                  st_ff <= S_DIV;
               end else begin
                  scan_ff <= scan_ff + CW'(1);
                  st_ff <= S_RD;
               end
            end
            // divider takes the full 36-bit in-region offset this cycle
            S_DIV: st_ff <= S_DIVW;
            S_DIVW: if (drsp.done) st_ff <= S_CALC;
            S_CALC: begin
               if (g_sum >= gcount_ff) begin
                  have_ff <= 1'b0;
                  seg_ff <= mk_seg(KIND_ZERO, '0, '0, '0, rem_ff, 1'b0, 1'b0);
               end else begin
                  seg_ff <= mk_seg(KIND_GROUP, drsp.rem[24:0], g_sum,
                                   rstart_ff + grel_cs, clen[16:0], 1'b0, 1'b0);
                  local_ff <= local_ff + clen;
               end
               st_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (n_ff == 5'(SEG_CAP - 1) && seg_ff.len < rem_ff) begin
                  seg_ff <= mk_seg(KIND_ZERO, '0, '0, '0, rem_ff, 1'b1, 1'b1);
                  rem_ff <= '0;
                  off_ff <= off_ff + {15'd0, rem_ff};
               end else begin
                  seg_ff.last <= (seg_ff.len == rem_ff);
                  rem_ff <= rem_ff - seg_ff.len;
                  off_ff <= off_ff + {15'd0, seg_ff.len};
               end
               n_ff <= n_ff + 5'd1;
               st_ff <= (seg_ff.kind == KIND_ZERO && seg_ff.len == rem_ff)
                        ? S_IDLE : S_STEP;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast = seg_ff.last;
   assign rsp_tdata = {7'd0, seg_ff.trunc, seg_ff.len, seg_ff.gdo, seg_ff.gidx,
                       seg_ff.src, seg_ff.kind};

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req_tready) else $error("accept while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("segment dropped");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("segment changed while stalled");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= 5'(SEG_CAP)) else $error("segment cap exceeded");
`endif
endmodule

/* hdl/dotgs_div.sv */
// Restoring divider, one quotient bit per cycle, 36-bit dividend, 26-bit divisor.
module dotgs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  dotgs_pkg::div_req_type req,
   output dotgs_pkg::div_rsp_type rsp
);
   import dotgs_pkg::*;

   logic [35:0] q_ff, q_in;
   logic [25:0] r_ff, r_in, d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [26:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[35]} - {1'b0, d_ff};
      if (req.start) begin
         q_in = req.dividend; r_in = '0; d_in = req.divisor;
         cnt_in = 6'd35; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[26]) begin
            r_in = trial[25:0];
            q_in = {q_ff[34:0], 1'b1};
         end else begin
            r_in = {r_ff[24:0], q_ff[35]};
            q_in = {q_ff[34:0], 1'b0};
         end
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;
   assign rsp.rem = r_ff;
endmodule

/* bench/disc_offset_to_group_segments_tb.sv */
// Testbench for the disc offset to group segment translator: self-checking scoreboard.
module disc_offset_to_group_segments_tb;
   import dotgs_pkg::*;

   localparam int unsigned MAX_CYCLES = 3000000;

   typedef struct {
      logic [1:0]  kind;
      logic [24:0] src;
      logic [31:0] gidx;
      logic [35:0] gdo;
      logic [16:0] len;
      logic        trunc;
      logic        last;
   } exp_seg_type;

   class seg_scoreboard;
      logic [25:0] chunk_size;
      logic [31:0] group_count;
      logic [4:0]  region_count;
      logic [35:0] reg_start [16];
      logic [35:0] reg_len [16];
      logic [31:0] reg_group [16];
      exp_seg_type pending[$];
      int          errors;

      function void clear();
         chunk_size = 26'd2097152;
         group_count = '0;
         region_count = '0;
         errors = 0;
         pending.delete();
      endfunction

      function void write_csr(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_CHUNK:  chunk_size = val[25:0];
            CSR_GCOUNT: group_count = val;
            CSR_RCOUNT: region_count = val[4:0];
            default: ;
         endcase
      endfunction

      // work out the segments a beat causes and queue them
      function void note_beat(logic typ, logic [159:0] d);
         logic [3:0]  slot;
         logic [35:0] off, skip;
         logic [36:0] grown;
         logic [63:0] offset, remaining, cs, local_off, nreg, grel, ing, g, left, len;
         int          cur, n;
         bit          have;
         exp_seg_type s;
         if (!typ) begin
            slot = d[3:0];
            off = d[39:4];
            skip = off % 36'h8000;
            grown = {1'b0, d[75:40]} + {1'b0, skip};
            reg_start[slot] = off - skip;
            reg_len[slot] = grown[36] ? 36'hFFFFFFFFF : grown[35:0];
            reg_group[slot] = d[107:76];
            return;
         end
         offset = 64'(d[139:108]);
         remaining = 64'(d[156:140]);
         if (remaining > 64'd65536) remaining = 64'd65536;
         cs = 64'(chunk_size);
         if (cs < CHUNK_MIN) cs = 64'(CHUNK_MIN);
         if (cs > CHUNK_MAX) cs = 64'(CHUNK_MAX);
         nreg = (region_count < 5'd16) ? 64'(region_count) : 64'd16;
         have = 0; cur = 0; local_off = '0; n = 0;
         while (remaining > 0 && n < SEG_CAP) begin
            s.kind = KIND_ZERO; s.src = '0; s.gidx = '0; s.gdo = '0; s.trunc = 1'b0;
            len = remaining;
            if (offset < HDR_BYTES) begin
               s.kind = KIND_HDR;
               s.src = 25'(offset);
               len = HDR_BYTES - offset;
               if (len > remaining) len = remaining;
               have = 0;
            end else begin
               if (!(have && local_off < reg_len[cur])) begin
                  have = 0;
                  for (int r = 0; r < nreg; r++)
                     if (!have && offset >= reg_start[r] &&
                         offset < 64'(reg_start[r]) + reg_len[r]) begin
                        have = 1; cur = r; local_off = offset - reg_start[r];
                     end
               end
               if (have) begin
                  grel = local_off / cs;
                  ing = local_off % cs;
                  g = (64'(reg_group[cur]) + grel) & 64'hFFFFFFFF;
                  if (g >= group_count) have = 0;
                  else begin
                     left = reg_len[cur] - local_off;
                     s.kind = KIND_GROUP;
                     s.src = 25'(ing);
                     s.gidx = g[31:0];
                     s.gdo = 36'(64'(reg_start[cur]) + grel * cs);
                     len = cs - ing;
                     if (len > remaining) len = remaining;
                     if (len > left) len = left;
                     local_off += len;
                  end
               end
            end
            if (n == SEG_CAP - 1 && len < remaining) begin
               s.kind = KIND_ZERO; s.src = '0; s.gidx = '0; s.gdo = '0;
               len = remaining; s.trunc = 1'b1;
            end
            remaining -= len;
            offset = (offset + len) & 64'hFFFFFFFF;
            s.len = len[16:0];
            s.last = (remaining == 0);
            pending.push_back(s);
            n++;
         end
      endfunction

      function void check_seg(logic [119:0] d, logic lst);
         exp_seg_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected segment %h last=%b", d, lst);
            return;
         end
         e = pending.pop_front();
         if (d[1:0] !== e.kind || d[26:2] !== e.src || d[58:27] !== e.gidx ||
             d[94:59] !== e.gdo || d[111:95] !== e.len || d[112] !== e.trunc ||
             lst !== e.last) begin
            errors++;
            if (errors <= 10)
               $display("seg mismatch exp k%0d s%h g%h o%h l%0d t%b e%b got k%0d s%h g%h o%h l%0d t%b e%b",
                  e.kind, e.src, e.gidx, e.gdo, e.len, e.trunc, e.last,
                  d[1:0], d[26:2], d[58:27], d[94:59], d[111:95], d[112], lst);
         end
      endfunction
   endclass

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tuser;
   logic [159:0] req_tdata;
   logic         rsp_tvalid, rsp_tready, rsp_tlast;
   logic [119:0] rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   disc_offset_to_group_segments dut (.*);

   seg_scoreboard sb;
   int  send_idle_pct, recv_idle_pct;
   bit  hold_off;
   int  cycles = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else begin
         if (rsp_tvalid && rsp_tready) sb.check_seg(rsp_tdata, rsp_tlast);
         rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // tvalid stays up after a beat until the next call idles or drain drops it
   task automatic send_beat(logic typ, logic [159:0] d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1; req_tuser <= typ; req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_beat(typ, d);
   endtask

   task automatic load_region(int slot, logic [35:0] off, logic [35:0] sz, logic [31:0] grp);
      logic [159:0] d;
      d = '0;
      d[3:0] = 4'(slot); d[39:4] = off; d[75:40] = sz; d[107:76] = grp;
      d[156:108] = 49'({$urandom, $urandom});
      send_beat(0, d);
   endtask

   task automatic read_req(logic [31:0] off, logic [16:0] len);
      logic [159:0] d;
      d = {$urandom, $urandom, $urandom, $urandom, $urandom};
      d[159:157] = '0;
      d[156:108] = {len, off};
      send_beat(1, d);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_csr(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      sb.write_csr(idx, val);
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_offset();
      case ($urandom_range(5))
         0: return 32'($urandom_range(200));
         1: return $urandom;
         default: return 32'($urandom_range(32'h00400000));
      endcase
   endfunction

   function automatic logic [16:0] pick_len();
      case ($urandom_range(5))
         0: return 17'(65536 + $urandom_range(65535));
         1: return 17'($urandom_range(17'h1FFFF, 1));
         default: return 17'($urandom_range(300, 1));
      endcase
   endfunction

   task automatic random_phase(int items);
      for (int i = 0; i < items; i++)
         if ($urandom_range(9) < 2) begin
            load_region($urandom_range(15),
                        36'({$urandom_range(15), $urandom} % 64'h800000),
                        36'($urandom_range(32'h00300000)), 32'($urandom_range(40)));
         end else read_req(pick_offset(), pick_len());
   endtask

   initial begin
      sb = new();
      sb.clear();
      hold_off = 0;
      send_idle_pct = 33; recv_idle_pct = 74;
      reset <= 1; req_tvalid <= 0; req_tuser <= 0; req_tdata <= '0;
      csr_we <= 0; csr_index <= CSR_CHUNK; csr_wdata <= 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table, header bytes, zero fill
      read_req(0, 1);
      read_req(32'd100, 17'd100);
      read_req(32'hFFFFFFF0, 17'h1FFFF);
      read_req(32'd500, 17'd0);
      drain();
      // fill every slot so later scans never read unwritten entries
      for (int s = 0; s < 16; s++)
         load_region(s, 36'h000100000 * s + 36'h1234 * s, 36'h000090000, 8 * s);
      load_region(15, 36'hFFFFFFFFF, 36'hFFFFFFFFF, 32'hFFFFFFFF);
      drain();
      set_csr(CSR_CHUNK, 0);
      set_csr(CSR_GCOUNT, 32'hFFFFFFFF);
      set_csr(CSR_RCOUNT, 31);
      read_req(32'd0, 17'd65536);
      read_req(32'h000F0000, 17'd20000);
      read_req(32'hFFFFFF00, 17'd4000);
      drain();
      set_csr(CSR_CHUNK, 32'h3FFFFFF);
      set_csr(CSR_GCOUNT, 3);
      set_csr(CSR_RCOUNT, 16);
      read_req(32'd64, 17'd65536);
      read_req(32'h00200010, 17'd5000);
      drain();
      set_csr(CSR_CHUNK, 32768);
      set_csr(CSR_GCOUNT, 200);
      set_csr(CSR_RCOUNT, 4);
      load_region(1, 36'h000100000, 36'h000004000, 0);
      load_region(2, 36'h000100000, 36'h000100000, 50);
      read_req(32'h00100100, 17'd65536);
      read_req(32'h00103F00, 17'd600);

      // long receiver hold-off while beats keep coming
      hold_off = 1;
      fork
         begin repeat (600) @(posedge clock); hold_off = 0; end
         for (int i = 0; i < 6; i++) read_req(pick_offset(), pick_len());
      join
      drain();

      set_csr(CSR_CHUNK, 32768 * $urandom_range(8, 1));
      set_csr(CSR_RCOUNT, 16);
      set_csr(CSR_GCOUNT, $urandom_range(120, 20));
      random_phase(32);
      drain();
      send_idle_pct = 74; recv_idle_pct = 33;
      set_csr(CSR_CHUNK, 32'd100000);
      set_csr(CSR_RCOUNT, $urandom_range(16, 8));
      random_phase(32);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      set_csr(CSR_CHUNK, 32'd2097152);
      set_csr(CSR_GCOUNT, 10000);
      random_phase(32);
      drain();

      if (sb.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
